@@ rtl/core/ltdc_pkg.sv @@
package ltdc_pkg;

    localparam int HALF_SIDE = 32;

    localparam int DIR_W = 3;
    localparam int CRD_W = 7;
    localparam int MAG_W = 7;
    localparam int LVL_W = 8;

    typedef logic [DIR_W-1:0] t_dir;
    typedef logic [MAG_W-1:0] t_mag;
    typedef logic [LVL_W-1:0] t_lvl;

    localparam t_mag HALF_MAG = MAG_W'(HALF_SIDE);
    localparam t_mag WRAP_MAG = MAG_W'(HALF_SIDE + 1);
    localparam t_lvl ROOT_LVL = LVL_W'(1);
    localparam t_lvl FAR_LVL  = LVL_W'(3 * HALF_SIDE);

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef struct packed {
        t_dir dir;
        logic neg_x;
        logic neg_y;
        logic neg_z;
        logic zero_x;
        logic zero_y;
        logic zero_z;
        logic half_x;
        logic half_y;
        logic half_z;
        logic wrap;
        t_lvl lvl;
    } t_cell;

    // Remainder by three through a reciprocal multiply, exact for any 8-bit level.
    function automatic logic [1:0] lvl_mod3(input t_lvl v);
        logic [16:0] prod;
        logic [7:0]  quot;
        logic [9:0]  triple;
        logic [9:0]  rem;
        prod   = 17'(v) * 17'd171;
        quot   = prod[16:9];
        triple = 10'(quot) * 10'd3;
        rem    = 10'(v) - triple;
        return rem[1:0];
    endfunction

endpackage

@@ rtl/core/ltdc_rule.sv @@
module ltdc_rule (
    input  ltdc_pkg::t_cell i_cell,
    output logic           o_allowed
);

    ltdc_pkg::t_dir sx;
    ltdc_pkg::t_dir sy;
    ltdc_pkg::t_dir sz;
    logic           even;
    logic [1:0]     spin;

    assign sx   = {2'b00, i_cell.neg_x};
    assign sy   = {2'b01, i_cell.neg_y};
    assign sz   = {2'b10, i_cell.neg_z};
    assign even = ~i_cell.lvl[0];
    assign spin = ltdc_pkg::lvl_mod3(i_cell.lvl);

    always_comb begin
        if (i_cell.wrap) begin
            o_allowed = 1'b0;
        end else if (i_cell.lvl == ltdc_pkg::ROOT_LVL || i_cell.lvl == ltdc_pkg::FAR_LVL) begin
            o_allowed = 1'b1;
        end else if (i_cell.half_x && i_cell.half_y) begin
            o_allowed = (i_cell.dir == sz);
        end else if (i_cell.half_x && i_cell.half_z) begin
            o_allowed = (i_cell.dir == sy);
        end else if (i_cell.half_y && i_cell.half_z) begin
            o_allowed = (i_cell.dir == sx);
        end else if (i_cell.zero_y && i_cell.zero_z) begin
            o_allowed = (i_cell.dir == sx);
        end else if (i_cell.zero_x && i_cell.zero_z) begin
            o_allowed = (i_cell.dir == sy);
        end else if (i_cell.zero_x && i_cell.zero_y) begin
            o_allowed = (i_cell.dir == sz);
        end else if (i_cell.half_z) begin
            if (i_cell.zero_y) begin
                o_allowed = (i_cell.dir == (even ? sx : sy));
            end else if (i_cell.zero_x) begin
                o_allowed = (i_cell.dir == (even ? sy : sx));
            end else begin
                o_allowed = (i_cell.dir == (even ? sx : sy));
            end
        end else if (i_cell.half_y) begin
            if (i_cell.zero_z) begin
                o_allowed = (i_cell.dir == (even ? sx : sz));
            end else if (i_cell.zero_x) begin
                o_allowed = (i_cell.dir == (even ? sz : sx));
            end else begin
                o_allowed = (i_cell.dir == (even ? sx : sz));
            end
        end else if (i_cell.half_x) begin
            if (i_cell.zero_y) begin
                o_allowed = (i_cell.dir == (even ? sz : sy));
            end else if (i_cell.zero_z) begin
                o_allowed = (i_cell.dir == (even ? sy : sz));
            end else begin
                o_allowed = (i_cell.dir == (even ? sz : sy));
            end
        end else if (i_cell.zero_z) begin
            o_allowed = (i_cell.dir == (even ? sx : sy));
        end else if (i_cell.zero_y) begin
            o_allowed = (i_cell.dir == (even ? sz : sx));
        end else if (i_cell.zero_x) begin
            o_allowed = (i_cell.dir == (even ? sy : sz));
        end else begin
            case (spin)
                ltdc_pkg::AXIS_X: o_allowed = (i_cell.dir == sx);
                ltdc_pkg::AXIS_Y: o_allowed = (i_cell.dir == sy);
                ltdc_pkg::AXIS_Z: o_allowed = (i_cell.dir == sz);
                default:          o_allowed = 1'b0;
            endcase
        end
    end

endmodule

@@ rtl/core/lattice_tree_direction_check_unit.sv @@
// Checks whether a direction code is a spanning-tree edge from a signed lattice cell.
// Each input word carries a direction and three 7-bit signed coordinates and gives
// one output word whose bit 0 is the allow flag. The unit is a three-stage pipeline
// (magnitudes, level and face flags, rule decision into the output register), and a
// new word is taken in every cycle while the output side accepts; a stall at the
// output holds all stages.
module lattice_tree_direction_check_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,  // direction[2:0], coord_x[9:3], coord_y[16:10], coord_z[23:17]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata   // allowed[0], zero padding[7:1]
);

    typedef struct packed {
        ltdc_pkg::t_dir dir;
        logic           neg_x;
        logic           neg_y;
        logic           neg_z;
        ltdc_pkg::t_mag ax;
        ltdc_pkg::t_mag ay;
        ltdc_pkg::t_mag az;
    } t_mag_stage;

    logic                     en;
    logic [ltdc_pkg::CRD_W-1:0] cx;
    logic [ltdc_pkg::CRD_W-1:0] cy;
    logic [ltdc_pkg::CRD_W-1:0] cz;
    t_mag_stage               n_s1;
    t_mag_stage               r_s1;
    logic                     r_v1;
    ltdc_pkg::t_cell          n_s2;
    ltdc_pkg::t_cell          r_s2;
    logic                     r_v2;
    logic                     rule_allowed;
    logic                     r_vo;
    logic                     r_allowed;

    assign en = ~r_vo | i_m_axis_tready;

    assign o_s_axis_tready = en;
    assign o_m_axis_tvalid = r_vo;
    assign o_m_axis_tdata  = {7'b0, r_allowed};

    assign cx = i_s_axis_tdata[9:3];
    assign cy = i_s_axis_tdata[16:10];
    assign cz = i_s_axis_tdata[23:17];

    always_comb begin
        n_s1.dir   = i_s_axis_tdata[2:0];
        n_s1.neg_x = cx[ltdc_pkg::CRD_W-1];
        n_s1.neg_y = cy[ltdc_pkg::CRD_W-1];
        n_s1.neg_z = cz[ltdc_pkg::CRD_W-1];
        n_s1.ax    = n_s1.neg_x ? ltdc_pkg::MAG_W'(-cx) : ltdc_pkg::MAG_W'(cx);
        n_s1.ay    = n_s1.neg_y ? ltdc_pkg::MAG_W'(-cy) : ltdc_pkg::MAG_W'(cy);
        n_s1.az    = n_s1.neg_z ? ltdc_pkg::MAG_W'(-cz) : ltdc_pkg::MAG_W'(cz);
    end

    always_comb begin
        n_s2.dir    = r_s1.dir;
        n_s2.neg_x  = r_s1.neg_x;
        n_s2.neg_y  = r_s1.neg_y;
        n_s2.neg_z  = r_s1.neg_z;
        n_s2.zero_x = (r_s1.ax == '0);
        n_s2.zero_y = (r_s1.ay == '0);
        n_s2.zero_z = (r_s1.az == '0);
        n_s2.half_x = (r_s1.ax == ltdc_pkg::HALF_MAG);
        n_s2.half_y = (r_s1.ay == ltdc_pkg::HALF_MAG);
        n_s2.half_z = (r_s1.az == ltdc_pkg::HALF_MAG);
        n_s2.wrap   = (r_s1.ax == ltdc_pkg::WRAP_MAG) || (r_s1.ay == ltdc_pkg::WRAP_MAG)
                   || (r_s1.az == ltdc_pkg::WRAP_MAG);
        n_s2.lvl    = ltdc_pkg::LVL_W'(r_s1.ax) + ltdc_pkg::LVL_W'(r_s1.ay)
                    + ltdc_pkg::LVL_W'(r_s1.az);
    end

    ltdc_rule u_rule (
        .i_cell    (r_s2),
        .o_allowed (rule_allowed)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_vo <= 1'b0;
        end else if (en) begin
            r_v1 <= i_s_axis_tvalid;
            r_v2 <= r_v1;
            r_vo <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1      <= n_s1;
            r_s2      <= n_s2;
            r_allowed <= rule_allowed;
        end
    end

    a_wrap_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_v2 && r_s2.wrap) |=> (r_vo && !o_m_axis_tdata[0]))
        else $error("wrap shell cell was not refused");

    a_root_allowed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_v2 && !r_s2.wrap && r_s2.lvl == ltdc_pkg::ROOT_LVL)
        |=> (r_vo && o_m_axis_tdata[0]))
        else $error("root level direction was refused");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> (r_v1 == $past(r_v1) && r_v2 == $past(r_v2) && $stable(r_s2)))
        else $error("pipeline stage moved during a stall");

    a_no_take_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vo && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("input word taken while the output is blocked");

endmodule
